// ===== hw/rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the match filter RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define MDMF_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// The expression must never be true outside reset.
`define MDMF_NEVER(name, clk, rst, expr, msg) \
  name: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

// ===== hw/rtl/mdmf_pkg.sv =====
// ---------------------------------------------------------------------------
// Match filter package
// Widths, register map, record types and controller/datapath links.
// ---------------------------------------------------------------------------
`default_nettype none

package mdmf_pkg;

  localparam int BUFFER_DEPTH = 64;
  localparam int IDX_W = $clog2(BUFFER_DEPTH);
  localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);

  localparam int QIDX_W = 16;
  localparam int TIDX_W = 16;
  localparam int IMG_W = 8;
  localparam int DIST_W = 16;

  localparam logic [DIST_W-1:0] MIN_START_RESET = 16'd6400;

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic [0:0] REG_MIN_START = 1'b0;

  typedef struct packed {
    logic [QIDX_W-1:0] query_index;
    logic [TIDX_W-1:0] train_index;
    logic [IMG_W-1:0]  image_index;
    logic [DIST_W-1:0] distance;
  } rec_t;

  typedef struct packed {
    rec_t rec;
    logic run_end;
    logic empty_run;
    logic overflowed;
  } res_t;

  typedef struct packed {
    logic load;
    logic rd_first;
    logic advance;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic last_entry;
    logic pass;
    logic pend_valid;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/mdmf_rec_if.sv =====
// ---------------------------------------------------------------------------
// Match filter channels
// Record request channel and result request channel.
// ---------------------------------------------------------------------------
`default_nettype none

interface mdmf_rec_if;
  import mdmf_pkg::*;

  logic              valid;
  logic              ready;
  logic [QIDX_W-1:0] query_index;
  logic [TIDX_W-1:0] train_index;
  logic [IMG_W-1:0]  image_index;
  logic [DIST_W-1:0] match_distance;
  logic              last_record;

  modport source (
    output valid, query_index, train_index, image_index, match_distance, last_record,
    input  ready
  );
  modport sink (
    input  valid, query_index, train_index, image_index, match_distance, last_record,
    output ready
  );
endinterface

interface mdmf_res_if;
  import mdmf_pkg::*;

  logic              valid;
  logic              ready;
  logic [QIDX_W-1:0] out_query_index;
  logic [TIDX_W-1:0] out_train_index;
  logic [IMG_W-1:0]  out_image_index;
  logic [DIST_W-1:0] out_distance;
  logic              run_end;
  logic              empty_run;
  logic              overflowed;

  modport source (
    output valid, out_query_index, out_train_index, out_image_index, out_distance,
    output run_end, empty_run, overflowed,
    input  ready
  );
  modport sink (
    input  valid, out_query_index, out_train_index, out_image_index, out_distance,
    input  run_end, empty_run, overflowed,
    output ready
  );
endinterface

`default_nettype wire

// ===== hw/rtl/mdmf_ctrl.sv =====
// ---------------------------------------------------------------------------
// Match filter controller
// Sequences record loading, buffer replay and the closing result.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module mdmf_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                rec_valid,
  input  wire logic                rec_last,
  output logic                     rec_ready,
  input  wire mdmf_pkg::dp_status_t status,
  output mdmf_pkg::dp_cmd_t        cmd
);
  import mdmf_pkg::*;

  typedef enum logic [1:0] {
    LOAD_S,
    READ_S,
    CHECK_S,
    FINISH_S
  } state_t;

  state_t state;
  state_t state_next;
  logic   stall;

  assign stall = status.pass && status.pend_valid && !status.out_free;

  always_comb begin
    state_next = state;
    cmd = '0;
    rec_ready = 1'b0;
    case (state)
      LOAD_S: begin
        rec_ready = 1'b1;
        cmd.load = rec_valid;
        if (rec_valid && rec_last) begin
          state_next = READ_S;
        end
      end
      READ_S: begin
        cmd.rd_first = 1'b1;
        state_next = CHECK_S;
      end
      CHECK_S: begin
        cmd.advance = !stall;
        if (!stall && status.last_entry) begin
          state_next = FINISH_S;
        end
      end
      FINISH_S: begin
        cmd.finish = status.out_free;
        if (status.out_free) begin
          state_next = LOAD_S;
        end
      end
      default: begin
        state_next = LOAD_S;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= LOAD_S;
    end else begin
      state <= state_next;
    end
  end

  `MDMF_ASSERT(a_cmd_onehot, clk, rst, $onehot0(cmd), "more than one datapath command")
  `MDMF_ASSERT(a_stall_holds, clk, rst, (state == CHECK_S && stall) |=> (state == CHECK_S), "replay left while stalled")
  `MDMF_ASSERT(a_last_starts_replay, clk, rst, (rec_valid && rec_ready && rec_last) |=> (state == READ_S), "last record did not start replay")
  `MDMF_ASSERT(a_finish_returns, clk, rst, cmd.finish |=> rec_ready, "finish did not return to loading")

endmodule

`default_nettype wire

// ===== hw/rtl/mdmf_datapath.sv =====
// ---------------------------------------------------------------------------
// Match filter datapath
// Record buffer, running minimum, replay compare and result register.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module mdmf_datapath (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire mdmf_pkg::dp_cmd_t     cmd,
  output mdmf_pkg::dp_status_t       status,
  input  wire mdmf_pkg::rec_t        rec_in,
  input  wire logic [15:0]           min_start,
  output mdmf_pkg::res_t             res_out,
  output logic                       res_valid,
  input  wire logic                  res_ready
);
  import mdmf_pkg::*;

  rec_t              mem [BUFFER_DEPTH];
  rec_t              rd_data;
  rec_t              pend;
  logic              pend_valid;
  logic [CNT_W-1:0]  count;
  logic              ovf;
  logic [DIST_W-1:0] run_min;
  logic [DIST_W-1:0] min_base;
  logic [DIST_W-1:0] min_next;
  logic [IDX_W-1:0]  scan_idx;
  logic [IDX_W-1:0]  rd_addr;
  logic              rd_en;
  logic              out_free;
  logic              pass;
  logic              last_entry;

  assign min_base = (count == '0 && !ovf) ? min_start : run_min;
  assign min_next = (rec_in.distance < min_base) ? rec_in.distance : min_base;

  assign pass = {1'b0, rd_data.distance} < {run_min, 1'b0};
  assign last_entry = CNT_W'(scan_idx) == (count - CNT_W'(1));
  assign out_free = !res_valid || res_ready;

  assign rd_en = cmd.rd_first || (cmd.advance && !last_entry);
  assign rd_addr = cmd.rd_first ? '0 : scan_idx + IDX_W'(1);

  assign status.last_entry = last_entry;
  assign status.pass = pass;
  assign status.pend_valid = pend_valid;
  assign status.out_free = out_free;

  always_ff @(posedge clk) begin
    if (cmd.load && count < CNT_W'(BUFFER_DEPTH)) begin
      mem[count[IDX_W-1:0]] <= rec_in;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      ovf <= 1'b0;
      pend_valid <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (cmd.finish || (cmd.advance && pass && pend_valid)) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
      if (cmd.load) begin
        run_min <= min_next;
        if (count < CNT_W'(BUFFER_DEPTH)) begin
          count <= count + CNT_W'(1);
        end else begin
          ovf <= 1'b1;
        end
      end
      if (cmd.rd_first) begin
        scan_idx <= '0;
      end
      if (cmd.advance) begin
        if (!last_entry) begin
          scan_idx <= scan_idx + IDX_W'(1);
        end
        if (pass) begin
          if (pend_valid) begin
            res_out.rec <= pend;
            res_out.run_end <= 1'b0;
            res_out.empty_run <= 1'b0;
            res_out.overflowed <= ovf;
          end
          pend <= rd_data;
          pend_valid <= 1'b1;
        end
      end
      if (cmd.finish) begin
        res_out.rec <= pend_valid ? pend : '0;
        res_out.run_end <= 1'b1;
        res_out.empty_run <= !pend_valid;
        res_out.overflowed <= ovf;
        pend_valid <= 1'b0;
        count <= '0;
        ovf <= 1'b0;
      end
    end
  end

  `MDMF_NEVER(a_count_bound, clk, rst, count > CNT_W'(BUFFER_DEPTH), "record count beyond depth")
  `MDMF_ASSERT(a_ovf_full, clk, rst, ovf |-> (count == CNT_W'(BUFFER_DEPTH)), "overflow with room left")
  `MDMF_ASSERT(a_finish_clears, clk, rst, cmd.finish |=> (count == '0 && !ovf && !pend_valid && res_valid), "run state not cleared")
  `MDMF_NEVER(a_no_overwrite, clk, rst, res_valid && !res_ready && (cmd.finish || (cmd.advance && pass && pend_valid)), "result overwritten while held")

endmodule

`default_nettype wire

// ===== hw/rtl/min_distance_match_filter_unit.sv =====
// ---------------------------------------------------------------------------
// Minimum-distance match filter
// Buffers a match list and returns the matches below twice the minimum.
// ---------------------------------------------------------------------------
// Records arrive on the records channel, one match per request, and are
// taken one per cycle while the block is loading. Up to 64 records are
// buffered; further records are dropped, though their distance still
// counts toward the minimum, and every result of the run is then flagged.
// A record with last_record set closes the list: the block stops taking
// records and replays the buffer, one stored record per cycle unless
// stalled, out of a single-port buffer with a registered read: it starts
// the read, checks each stored record and then emits the closing result.
// Each match whose distance is below twice the minimum leaves on the
// results channel; the final one has run_end set, and a run with no
// passing match gives one empty result. A held result register lets the
// replay continue until a second result is due; a stalled receiver then
// pauses the replay. The min_start register, at byte address 0 of the APB
// port, seeds the minimum of every run.
// Reset empties the buffer, drops any pending result and sets min_start
// back to 6400.
// ---------------------------------------------------------------------------
`default_nettype none

module min_distance_match_filter_unit (
  input  wire logic                             clk,
  input  wire logic                             rst,
  mdmf_rec_if.sink                              records,
  mdmf_res_if.source                            results,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [mdmf_pkg::APB_ADDR_W-1:0]  paddr,
  input  wire logic [mdmf_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [mdmf_pkg::APB_DATA_W-1:0]       prdata,
  output logic                                  pready
);
  import mdmf_pkg::*;

  logic [DIST_W-1:0] min_start;
  logic              reg_sel;
  dp_cmd_t           cmd;
  dp_status_t        status;
  rec_t              rec_in;
  res_t              res_out;
  logic              res_valid;
  logic              rec_ready;

  assign pready = 1'b1;
  assign reg_sel = paddr[APB_ADDR_W-1] == REG_MIN_START;
  assign prdata = reg_sel ? APB_DATA_W'(min_start) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_start <= MIN_START_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      min_start <= pwdata[DIST_W-1:0];
    end
  end

  assign rec_in.query_index = records.query_index;
  assign rec_in.train_index = records.train_index;
  assign rec_in.image_index = records.image_index;
  assign rec_in.distance = records.match_distance;
  assign records.ready = rec_ready;

  mdmf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .rec_valid (records.valid),
    .rec_last  (records.last_record),
    .rec_ready (rec_ready),
    .status    (status),
    .cmd       (cmd)
  );

  mdmf_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .rec_in    (rec_in),
    .min_start (min_start),
    .res_out   (res_out),
    .res_valid (res_valid),
    .res_ready (results.ready)
  );

  assign results.valid = res_valid;
  assign results.out_query_index = res_out.rec.query_index;
  assign results.out_train_index = res_out.rec.train_index;
  assign results.out_image_index = res_out.rec.image_index;
  assign results.out_distance = res_out.rec.distance;
  assign results.run_end = res_out.run_end;
  assign results.empty_run = res_out.empty_run;
  assign results.overflowed = res_out.overflowed;

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
// ---------------------------------------------------------------------------
// Minimum-distance match filter testbench
// Sends match lists to the block and checks every returned match against a
// built-in model of the filter. Directed lists cover the field extremes, the
// strict threshold, the starting minimum and an unmapped register write.
// Random lists follow under several starting minimums, with one list that
// overflows the buffer. Both channels idle and stall at random.
// ---------------------------------------------------------------------------
module testbench;
  import mdmf_pkg::*;

  localparam int unsigned RUN_LIMIT = 400000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int REG_UNMAPPED = 1;

  class match_filter_scoreboard;
    logic [DIST_W-1:0] min_start;
    rec_t              stored[BUFFER_DEPTH];
    int unsigned       stored_count;
    logic [DIST_W-1:0] running_min;
    bit                dropped;
    res_t              pending_matches[$];
    int                errors;

    function new();
      min_start = MIN_START_RESET;
      running_min = MIN_START_RESET;
      stored_count = 0;
      dropped = 1'b0;
      errors = 0;
    endfunction

    function void fail(string msg);
      errors++;
      if (errors <= 10) $display("%s", msg);
    endfunction

    function void set_min_start(logic [DIST_W-1:0] value);
      min_start = value;
    endfunction

    function void queue_match(res_t m);
      pending_matches.insert(pending_matches.size(), m);
    endfunction

    // Stores one record and, on the closing record, queues the passing matches.
    function void take_record(rec_t rec, logic last);
      logic [DIST_W:0] threshold;
      res_t            match;
      int              passed;
      if (stored_count == 0 && !dropped) running_min = min_start;
      if (stored_count < BUFFER_DEPTH) begin
        stored[stored_count] = rec;
        stored_count++;
      end else begin
        dropped = 1'b1;
      end
      if (rec.distance < running_min) running_min = rec.distance;
      if (!last) return;
      threshold = {running_min, 1'b0};
      passed = 0;
      for (int unsigned i = 0; i < stored_count; i++) begin
        if ({1'b0, stored[i].distance} < threshold) begin
          match.rec = stored[i];
          match.run_end = 1'b0;
          match.empty_run = 1'b0;
          match.overflowed = dropped;
          queue_match(match);
          passed++;
        end
      end
      if (passed == 0) begin
        match = '0;
        match.run_end = 1'b1;
        match.empty_run = 1'b1;
        match.overflowed = dropped;
        queue_match(match);
      end else begin
        pending_matches[pending_matches.size() - 1].run_end = 1'b1;
      end
      stored_count = 0;
      dropped = 1'b0;
      running_min = min_start;
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (pending_matches.size() == 0) begin
        fail($sformatf("unexpected result: q=%h t=%h img=%h d=%h end=%b empty=%b ovf=%b",
                       got.rec.query_index, got.rec.train_index, got.rec.image_index,
                       got.rec.distance, got.run_end, got.empty_run, got.overflowed));
        return;
      end
      want = pending_matches.pop_front();
      if (got.rec.query_index !== want.rec.query_index ||
          got.rec.train_index !== want.rec.train_index ||
          got.rec.image_index !== want.rec.image_index ||
          got.rec.distance !== want.rec.distance ||
          got.run_end !== want.run_end ||
          got.empty_run !== want.empty_run ||
          got.overflowed !== want.overflowed) begin
        fail($sformatf({"result mismatch: expected q=%h t=%h img=%h d=%h end=%b empty=%b ",
                        "ovf=%b, got q=%h t=%h img=%h d=%h end=%b empty=%b ovf=%b"},
                       want.rec.query_index, want.rec.train_index, want.rec.image_index,
                       want.rec.distance, want.run_end, want.empty_run, want.overflowed,
                       got.rec.query_index, got.rec.train_index, got.rec.image_index,
                       got.rec.distance, got.run_end, got.empty_run, got.overflowed));
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  mdmf_rec_if records_ch ();
  mdmf_res_if results_ch ();

  match_filter_scoreboard sb;
  bit                     no_idle = 1'b0;
  int unsigned            cycle_count = 0;
  int unsigned            rx_hold = 0;

  always #1 clk = ~clk;

  min_distance_match_filter_unit uut (
    .clk     (clk),
    .rst     (rst),
    .records (records_ch),
    .results (results_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (no_idle) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic rec_t random_record(int unsigned base);
    rec_t        rec;
    int unsigned raw_distance;
    rec.query_index = QIDX_W'($urandom_range(0, 65535));
    rec.train_index = TIDX_W'($urandom_range(0, 65535));
    rec.image_index = IMG_W'($urandom_range(0, 255));
    if ($urandom_range(0, 6) == 0) begin
      raw_distance = $urandom_range(0, 65535);
    end else begin
      raw_distance = base + $urandom_range(0, base + base / 4);
      if (raw_distance > 65535) raw_distance = 65535;
    end
    rec.distance = DIST_W'(raw_distance);
    return rec;
  endfunction

  task automatic reg_write(int index, logic [APB_DATA_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= APB_ADDR_W'(4 * index);
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    if (index == REG_MIN_START) sb.set_min_start(value[DIST_W-1:0]);
  endtask

  task automatic reg_check();
    logic [APB_DATA_W-1:0] seen;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= APB_ADDR_W'(4 * REG_MIN_START);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    seen = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    if (seen[DIST_W-1:0] !== sb.min_start) begin
      sb.fail($sformatf("min_start readback mismatch: expected %h, got %h",
                        sb.min_start, seen[DIST_W-1:0]));
    end
  endtask

  task automatic send_record(rec_t rec, logic last);
    int unsigned gap;
    records_ch.valid <= 1'b1;
    records_ch.query_index <= rec.query_index;
    records_ch.train_index <= rec.train_index;
    records_ch.image_index <= rec.image_index;
    records_ch.match_distance <= rec.distance;
    records_ch.last_record <= last;
    do @(posedge clk); while (records_ch.ready !== 1'b1);
    gap = pick_gap();
    if (gap > 0) begin
      records_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_list(int unsigned length, int unsigned base);
    for (int unsigned i = 0; i < length; i++) begin
      send_record(random_record(base), i == length - 1);
    end
  endtask

  // The sender holds off until every queued match has come back.
  task automatic drain();
    records_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_matches.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RUN_LIMIT) begin
      $display("FAIL min_distance_match_filter_unit");
      $finish;
    end
  end

  always @(posedge clk) begin
    rec_t taken;
    res_t seen;
    if (!rst) begin
      if (records_ch.valid === 1'b1 && records_ch.ready === 1'b1) begin
        taken.query_index = records_ch.query_index;
        taken.train_index = records_ch.train_index;
        taken.image_index = records_ch.image_index;
        taken.distance = records_ch.match_distance;
        sb.take_record(taken, records_ch.last_record);
      end
      if (results_ch.valid === 1'b1 && results_ch.ready === 1'b1) begin
        seen.rec.query_index = results_ch.out_query_index;
        seen.rec.train_index = results_ch.out_train_index;
        seen.rec.image_index = results_ch.out_image_index;
        seen.rec.distance = results_ch.out_distance;
        seen.run_end = results_ch.run_end;
        seen.empty_run = results_ch.empty_run;
        seen.overflowed = results_ch.overflowed;
        sb.check_result(seen);
      end
    end
  end

  initial begin
    results_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold > 0) begin
        rx_hold--;
        results_ch.ready <= 1'b0;
      end else begin
        results_ch.ready <= 1'b1;
        rx_hold = pick_gap();
      end
    end
  end

  initial begin
    int unsigned       budget[5];
    logic [DIST_W-1:0] phase_min[5];
    int unsigned       sent;
    int unsigned       length;
    int unsigned       base;
    bit                paused;

    sb = new();
    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    records_ch.valid <= 1'b0;
    records_ch.query_index <= '0;
    records_ch.train_index <= '0;
    records_ch.image_index <= '0;
    records_ch.match_distance <= '0;
    records_ch.last_record <= 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    reg_check();

    // With the reset minimum of 100.0, a single maximal record does not pass.
    send_record(rec_t'{16'hffff, 16'hffff, 8'hff, 16'hffff}, 1'b1);
    // A zero distance makes the threshold zero, so nothing passes.
    send_record(rec_t'{16'h0000, 16'h0000, 8'h00, 16'd0}, 1'b0);
    send_record(rec_t'{16'h0001, 16'h0002, 8'h03, 16'd100}, 1'b1);
    // A distance equal to twice the minimum is rejected.
    send_record(rec_t'{16'($urandom), 16'($urandom), 8'($urandom), 16'd1000}, 1'b0);
    send_record(rec_t'{16'($urandom), 16'($urandom), 8'($urandom), 16'd1999}, 1'b0);
    send_record(rec_t'{16'($urandom), 16'($urandom), 8'($urandom), 16'd2000}, 1'b0);
    send_record(rec_t'{16'($urandom), 16'($urandom), 8'($urandom), 16'd1500}, 1'b1);
    // All distances at or above the starting minimum: the threshold stays at 200.0.
    send_record(rec_t'{16'($urandom), 16'($urandom), 8'($urandom), 16'd6400}, 1'b0);
    send_record(rec_t'{16'($urandom), 16'($urandom), 8'($urandom), 16'd12799}, 1'b0);
    send_record(rec_t'{16'($urandom), 16'($urandom), 8'($urandom), 16'd12800}, 1'b1);
    drain();

    reg_write(REG_UNMAPPED, 32'h0000_1234);
    reg_check();
    reg_write(REG_MIN_START, 32'd0);
    reg_check();
    send_record(rec_t'{16'($urandom), 16'($urandom), 8'($urandom), 16'd5}, 1'b0);
    send_record(rec_t'{16'($urandom), 16'($urandom), 8'($urandom), 16'd0}, 1'b1);
    drain();

    // The doubled minimum needs 17 bits here.
    reg_write(REG_MIN_START, 32'd65535);
    reg_check();
    send_record(rec_t'{16'($urandom), 16'($urandom), 8'($urandom), 16'd40000}, 1'b0);
    send_record(rec_t'{16'($urandom), 16'($urandom), 8'($urandom), 16'd65535}, 1'b1);
    drain();

    budget[0] = 8;
    budget[1] = 8;
    budget[2] = 6;
    budget[3] = 4;
    budget[4] = 4;
    phase_min[0] = MIN_START_RESET;
    phase_min[1] = DIST_W'($urandom_range(0, 65535));
    phase_min[2] = 16'hffff;
    phase_min[3] = 16'h0000;
    phase_min[4] = DIST_W'($urandom_range(16384, 65535));
    paused = 1'b0;
    for (int p = 0; p < 5; p++) begin
      no_idle = (p == 2);
      reg_write(REG_MIN_START, {{(APB_DATA_W - DIST_W){1'b0}}, phase_min[p]});
      reg_check();
      sent = 0;
      while (sent < budget[p]) begin
        length = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 8) : $urandom_range(9, 20);
        base = $urandom_range(0, 40000);
        send_list(length, base);
        sent += length;
        if (p == 1 && !paused && sent >= 4) begin
          drain();
          paused = 1'b1;
        end
      end
      if (p == 4) begin
        // Overflowing list: the dropped closing record still lowers the minimum.
        base = $urandom_range(4000, 30000);
        length = $urandom_range(65, 68);
        for (int unsigned i = 0; i < length - 1; i++) begin
          send_record(random_record(base), 1'b0);
        end
        send_record(rec_t'{16'($urandom), 16'($urandom), 8'($urandom), DIST_W'(base * 3 / 4)},
                    1'b1);
      end
      drain();
    end
    no_idle = 1'b0;

    if (sb.errors == 0 && sb.pending_matches.size() == 0) begin
      $display("PASS min_distance_match_filter_unit");
    end else begin
      $display("FAIL min_distance_match_filter_unit");
    end
    $finish;
  end

endmodule
